FILE: rtl/gsup_pkg.sv
// Shared types and constants of the greenhouse climate supervisor.
`default_nettype none

package gsup_pkg;

  localparam int unsigned CfgWidth  = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam logic [7:0]  Hyst      = 8'd5;

  // activity flag bits
  localparam int unsigned FlWait  = 0;
  localparam int unsigned FlAlarm = 1;
  localparam int unsigned FlWater = 2;
  localparam int unsigned FlWarm  = 3;
  localparam int unsigned FlCool  = 4;
  localparam int unsigned FlVent  = 5;
  localparam int unsigned FlCare  = 6;
  localparam int unsigned NumFlags = 7;

  // actuator bits
  localparam int unsigned ActValve = 0;
  localparam int unsigned ActAlarm = 1;
  localparam int unsigned ActFan   = 2;
  localparam int unsigned ActLamp  = 3;
  localparam int unsigned NumActs  = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HUM_LOW     = 3'd0,
    CFG_SOIL_TARGET = 3'd1,
    CFG_SOIL_START  = 3'd2,
    CFG_COLD_LIMIT  = 3'd3,
    CFG_HOT_LIMIT   = 3'd4,
    CFG_SUPPLY_TANK = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_WAITING     = 3'd0,
    ST_ALARM       = 3'd1,
    ST_WATERING    = 3'd2,
    ST_WARMING     = 3'd3,
    ST_COOLING     = 3'd4,
    ST_VENTILATING = 3'd5,
    ST_CARING      = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    SUP_RESET = 3'b001,
    SUP_WAIT  = 3'b010,
    SUP_CARE  = 3'b100
  } sup_phase_e;

  typedef enum logic [4:0] {
    IRR_RESET    = 5'b00001,
    IRR_IDLE     = 5'b00010,
    IRR_WATERED  = 5'b00100,
    IRR_WATERING = 5'b01000,
    IRR_ALARM    = 5'b10000
  } irr_phase_e;

  typedef enum logic [3:0] {
    HUM_RESET  = 4'b0001,
    HUM_IDLE   = 4'b0010,
    HUM_CALM   = 4'b0100,
    HUM_VENT   = 4'b1000
  } hum_phase_e;

  typedef enum logic [4:0] {
    THR_RESET  = 5'b00001,
    THR_IDLE   = 5'b00010,
    THR_STABLE = 5'b00100,
    THR_WARM   = 5'b01000,
    THR_COOL   = 5'b10000
  } thr_phase_e;

  typedef struct packed {
    logic [7:0] air_humidity_low;
    logic [7:0] soil_moisture_target;
    logic [7:0] soil_moisture_start;
    logic [7:0] temp_cold_limit;
    logic [7:0] temp_hot_limit;
    logic       supply_from_tank;
  } cfg_t;

  typedef struct packed {
    logic       care_request;
    logic [7:0] soil_moisture;
    logic [7:0] air_humidity;
    logic [7:0] temperature;
    logic       tank_level_low;
    logic       valve_time_up;
    logic       settle_time_up;
  } tick_in_t;

  typedef struct packed {
    logic       valve_open;
    logic       alarm_active;
    logic       fan_running;
    logic       lamp_lit;
    logic       begin_valve_timer;
    logic       begin_settle_timer;
    logic       cancel_timers;
    logic       caring_active;
    logic [2:0] status_code;
  } tick_out_t;

endpackage

`default_nettype wire

FILE: rtl/gsup_in_if.sv
// Input channel interface: one control tick per transaction.
`default_nettype none

interface gsup_in_if;
  logic       valid;
  logic       ready;
  logic       care_request;
  logic [7:0] soil_moisture;
  logic [7:0] air_humidity;
  logic [7:0] temperature;
  logic       tank_level_low;
  logic       valve_time_up;
  logic       settle_time_up;

  modport source (
    output valid, care_request, soil_moisture, air_humidity, temperature,
           tank_level_low, valve_time_up, settle_time_up,
    input  ready
  );

  modport sink (
    input  valid, care_request, soil_moisture, air_humidity, temperature,
           tank_level_low, valve_time_up, settle_time_up,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/gsup_out_if.sv
// Result channel interface: actuator levels, timer strobes and status.
`default_nettype none

interface gsup_out_if;
  logic       valid;
  logic       ready;
  logic       valve_open;
  logic       alarm_active;
  logic       fan_running;
  logic       lamp_lit;
  logic       begin_valve_timer;
  logic       begin_settle_timer;
  logic       cancel_timers;
  logic       caring_active;
  logic [2:0] status_code;

  modport source (
    output valid, valve_open, alarm_active, fan_running, lamp_lit,
           begin_valve_timer, begin_settle_timer, cancel_timers,
           caring_active, status_code,
    input  ready
  );

  modport sink (
    input  valid, valve_open, alarm_active, fan_running, lamp_lit,
           begin_valve_timer, begin_settle_timer, cancel_timers,
           caring_active, status_code,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/gsup_cfg_regs.sv
// Configuration register file of the climate supervisor.
`default_nettype none

module gsup_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [gsup_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [gsup_pkg::CfgWidth-1:0]   cfg_data_i,
  output gsup_pkg::cfg_t                       cfg_o
);

  gsup_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (gsup_pkg::cfg_idx_e'(cfg_idx_i))
        gsup_pkg::CFG_HUM_LOW:     cfg_d.air_humidity_low     = cfg_data_i;
        gsup_pkg::CFG_SOIL_TARGET: cfg_d.soil_moisture_target = cfg_data_i;
        gsup_pkg::CFG_SOIL_START:  cfg_d.soil_moisture_start  = cfg_data_i;
        gsup_pkg::CFG_COLD_LIMIT:  cfg_d.temp_cold_limit      = cfg_data_i;
        gsup_pkg::CFG_HOT_LIMIT:   cfg_d.temp_hot_limit       = cfg_data_i;
        gsup_pkg::CFG_SUPPLY_TANK: cfg_d.supply_from_tank     = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.air_humidity_low     <= 8'd0;
      cfg_q.soil_moisture_target <= 8'd0;
      cfg_q.soil_moisture_start  <= 8'd0;
      cfg_q.temp_cold_limit      <= 8'd0;
      cfg_q.temp_hot_limit       <= 8'd255;
      cfg_q.supply_from_tank     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/gsup_tick.sv
// Supervisor, irrigation, ventilation and thermal machines for one control tick.
`default_nettype none

module gsup_tick (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire gsup_pkg::cfg_t     cfg_i,
  input  wire gsup_pkg::tick_in_t item_i,
  output gsup_pkg::tick_out_t     res_o
);

  gsup_pkg::sup_phase_e sup_q, sup_d;
  gsup_pkg::irr_phase_e irr_q, irr_d;
  gsup_pkg::hum_phase_e hum_q, hum_d;
  gsup_pkg::thr_phase_e thr_q, thr_d;
  gsup_pkg::status_e    held_q, held_d;
  logic                 caring_q, caring_d;
  logic [gsup_pkg::NumFlags-1:0] flags_q, flags_d;
  logic [gsup_pkg::NumActs-1:0]  act_q, act_d;

  logic       st_valve, st_settle, st_cancel;
  logic       empty;
  logic [7:0] hum_hi, cold_off, hot_off;

  assign empty    = cfg_i.supply_from_tank & item_i.tank_level_low;
  assign hum_hi   = cfg_i.air_humidity_low + gsup_pkg::Hyst;
  assign cold_off = cfg_i.temp_cold_limit + gsup_pkg::Hyst;
  assign hot_off  = cfg_i.temp_hot_limit - gsup_pkg::Hyst;

  // Machines run in order; later ones see what earlier ones wrote this tick.
  always_comb begin
    sup_d     = sup_q;
    irr_d     = irr_q;
    hum_d     = hum_q;
    thr_d     = thr_q;
    caring_d  = caring_q;
    flags_d   = flags_q;
    act_d     = act_q;
    st_valve  = 1'b0;
    st_settle = 1'b0;
    st_cancel = 1'b0;

    case (sup_q)
      gsup_pkg::SUP_RESET: begin
        caring_d = 1'b0;
        sup_d    = gsup_pkg::SUP_WAIT;
      end
      gsup_pkg::SUP_WAIT: begin
        flags_d[gsup_pkg::FlWait] = 1'b1;
        if (item_i.care_request) begin
          caring_d = 1'b1;
          sup_d    = gsup_pkg::SUP_CARE;
          flags_d[gsup_pkg::FlCare] = 1'b1;
          flags_d[gsup_pkg::FlWait] = 1'b0;
        end
      end
      gsup_pkg::SUP_CARE: begin
        if (!item_i.care_request) begin
          flags_d[gsup_pkg::FlCare] = 1'b0;
          caring_d = 1'b0;
          sup_d    = gsup_pkg::SUP_WAIT;
        end
      end
      default: sup_d = gsup_pkg::SUP_RESET;
    endcase

    case (irr_q)
      gsup_pkg::IRR_RESET: begin
        act_d[gsup_pkg::ActValve] = 1'b0;
        act_d[gsup_pkg::ActAlarm] = 1'b0;
        irr_d = gsup_pkg::IRR_IDLE;
      end
      gsup_pkg::IRR_IDLE: begin
        if (caring_d) irr_d = gsup_pkg::IRR_WATERED;
      end
      gsup_pkg::IRR_WATERED: begin
        if (item_i.soil_moisture < cfg_i.soil_moisture_start && !empty) begin
          act_d[gsup_pkg::ActValve] = 1'b1;
          st_valve = 1'b1;
          flags_d[gsup_pkg::FlWater] = 1'b1;
          irr_d = gsup_pkg::IRR_WATERING;
        end
        if (empty) begin
          act_d[gsup_pkg::ActAlarm] = 1'b1;
          flags_d[gsup_pkg::FlAlarm] = 1'b1;
          irr_d = gsup_pkg::IRR_ALARM;
        end
        if (!caring_d) irr_d = gsup_pkg::IRR_IDLE;
      end
      gsup_pkg::IRR_WATERING: begin
        if (item_i.valve_time_up) begin
          st_settle = 1'b1;
          act_d[gsup_pkg::ActValve] = 1'b0;
        end
        if (empty) begin
          act_d[gsup_pkg::ActValve] = 1'b0;
          st_cancel = 1'b1;
          st_valve  = 1'b0;
          st_settle = 1'b0;
          act_d[gsup_pkg::ActAlarm] = 1'b1;
          flags_d[gsup_pkg::FlAlarm] = 1'b1;
          irr_d = gsup_pkg::IRR_ALARM;
        end
        if (item_i.soil_moisture >= cfg_i.soil_moisture_target) begin
          act_d[gsup_pkg::ActValve] = 1'b0;
          st_cancel = 1'b1;
          st_valve  = 1'b0;
          st_settle = 1'b0;
          flags_d[gsup_pkg::FlWater] = 1'b0;
          irr_d = gsup_pkg::IRR_WATERED;
        end
        if (item_i.settle_time_up &&
            item_i.soil_moisture <= cfg_i.soil_moisture_target) begin
          act_d[gsup_pkg::ActValve] = 1'b1;
          st_valve = 1'b1;
          irr_d = gsup_pkg::IRR_WATERING;
        end
        if (!caring_d) begin
          act_d[gsup_pkg::ActValve] = 1'b0;
          st_cancel = 1'b1;
          st_valve  = 1'b0;
          st_settle = 1'b0;
          flags_d[gsup_pkg::FlWater] = 1'b0;
          irr_d = gsup_pkg::IRR_IDLE;
        end
      end
      gsup_pkg::IRR_ALARM: begin
        if (!empty) begin
          act_d[gsup_pkg::ActAlarm] = 1'b0;
          flags_d[gsup_pkg::FlAlarm] = 1'b0;
          irr_d = gsup_pkg::IRR_WATERED;
        end
        if (!caring_d) begin
          act_d[gsup_pkg::ActAlarm] = 1'b0;
          flags_d[gsup_pkg::FlAlarm] = 1'b0;
          irr_d = gsup_pkg::IRR_IDLE;
        end
      end
      default: irr_d = gsup_pkg::IRR_RESET;
    endcase

    case (hum_q)
      gsup_pkg::HUM_RESET: begin
        act_d[gsup_pkg::ActFan] = 1'b0;
        hum_d = gsup_pkg::HUM_IDLE;
      end
      gsup_pkg::HUM_IDLE: begin
        if (caring_d) hum_d = gsup_pkg::HUM_CALM;
      end
      gsup_pkg::HUM_CALM: begin
        if (item_i.air_humidity >= hum_hi) begin
          act_d[gsup_pkg::ActFan] = 1'b1;
          flags_d[gsup_pkg::FlVent] = 1'b1;
          hum_d = gsup_pkg::HUM_VENT;
        end
        if (!caring_d) hum_d = gsup_pkg::HUM_IDLE;
      end
      gsup_pkg::HUM_VENT: begin
        if (item_i.air_humidity <= cfg_i.air_humidity_low) begin
          // keep the fan if cooling still owns it
          if (!flags_d[gsup_pkg::FlCool]) act_d[gsup_pkg::ActFan] = 1'b0;
          flags_d[gsup_pkg::FlVent] = 1'b0;
          hum_d = gsup_pkg::HUM_CALM;
        end
        if (!caring_d) begin
          act_d[gsup_pkg::ActFan] = 1'b0;
          flags_d[gsup_pkg::FlVent] = 1'b0;
          hum_d = gsup_pkg::HUM_IDLE;
        end
      end
      default: hum_d = gsup_pkg::HUM_RESET;
    endcase

    case (thr_q)
      gsup_pkg::THR_RESET: begin
        act_d[gsup_pkg::ActLamp] = 1'b0;
        act_d[gsup_pkg::ActFan]  = 1'b0;
        thr_d = gsup_pkg::THR_IDLE;
      end
      gsup_pkg::THR_IDLE: begin
        if (caring_d) thr_d = gsup_pkg::THR_STABLE;
      end
      gsup_pkg::THR_STABLE: begin
        if (item_i.temperature <= cfg_i.temp_cold_limit) begin
          act_d[gsup_pkg::ActLamp] = 1'b1;
          flags_d[gsup_pkg::FlWarm] = 1'b1;
          thr_d = gsup_pkg::THR_WARM;
        end
        if (item_i.temperature >= cfg_i.temp_hot_limit) begin
          act_d[gsup_pkg::ActFan] = 1'b1;
          flags_d[gsup_pkg::FlCool] = 1'b1;
          thr_d = gsup_pkg::THR_COOL;
        end
        if (!caring_d) begin
          flags_d[gsup_pkg::FlWarm] = 1'b0;
          flags_d[gsup_pkg::FlCool] = 1'b0;
          thr_d = gsup_pkg::THR_IDLE;
        end
      end
      gsup_pkg::THR_WARM: begin
        if (item_i.temperature >= cold_off) begin
          act_d[gsup_pkg::ActLamp] = 1'b0;
          flags_d[gsup_pkg::FlWarm] = 1'b0;
          thr_d = gsup_pkg::THR_STABLE;
        end
        if (!caring_d) begin
          act_d[gsup_pkg::ActLamp] = 1'b0;
          flags_d[gsup_pkg::FlWarm] = 1'b0;
          thr_d = gsup_pkg::THR_IDLE;
        end
      end
      gsup_pkg::THR_COOL: begin
        if (item_i.temperature <= hot_off) begin
          if (!flags_d[gsup_pkg::FlVent]) act_d[gsup_pkg::ActFan] = 1'b0;
          flags_d[gsup_pkg::FlCool] = 1'b0;
          thr_d = gsup_pkg::THR_STABLE;
        end
        if (!caring_d) begin
          act_d[gsup_pkg::ActFan] = 1'b0;
          flags_d[gsup_pkg::FlCool] = 1'b0;
          thr_d = gsup_pkg::THR_IDLE;
        end
      end
      default: thr_d = gsup_pkg::THR_RESET;
    endcase

    held_d = held_q;
    if (flags_d[gsup_pkg::FlWait])       held_d = gsup_pkg::ST_WAITING;
    else if (flags_d[gsup_pkg::FlAlarm]) held_d = gsup_pkg::ST_ALARM;
    else if (flags_d[gsup_pkg::FlWater]) held_d = gsup_pkg::ST_WATERING;
    else if (flags_d[gsup_pkg::FlWarm])  held_d = gsup_pkg::ST_WARMING;
    else if (flags_d[gsup_pkg::FlCool])  held_d = gsup_pkg::ST_COOLING;
    else if (flags_d[gsup_pkg::FlVent])  held_d = gsup_pkg::ST_VENTILATING;
    else if (flags_d[gsup_pkg::FlCare])  held_d = gsup_pkg::ST_CARING;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sup_q    <= gsup_pkg::SUP_RESET;
      irr_q    <= gsup_pkg::IRR_RESET;
      hum_q    <= gsup_pkg::HUM_RESET;
      thr_q    <= gsup_pkg::THR_RESET;
      held_q   <= gsup_pkg::ST_WAITING;
      caring_q <= 1'b0;
      flags_q  <= '0;
      act_q    <= '0;
    end else if (fire_i) begin
      sup_q    <= sup_d;
      irr_q    <= irr_d;
      hum_q    <= hum_d;
      thr_q    <= thr_d;
      held_q   <= held_d;
      caring_q <= caring_d;
      flags_q  <= flags_d;
      act_q    <= act_d;
    end
  end

  assign res_o.valve_open         = act_d[gsup_pkg::ActValve];
  assign res_o.alarm_active       = act_d[gsup_pkg::ActAlarm];
  assign res_o.fan_running        = act_d[gsup_pkg::ActFan];
  assign res_o.lamp_lit           = act_d[gsup_pkg::ActLamp];
  assign res_o.begin_valve_timer  = st_valve;
  assign res_o.begin_settle_timer = st_settle;
  assign res_o.cancel_timers      = st_cancel;
  assign res_o.caring_active      = caring_d;
  assign res_o.status_code        = held_d;

endmodule

`default_nettype wire

FILE: rtl/greenhouse_climate_supervisor_unit.sv
// Path: a transaction is captured in the input register, then the tick logic writes its result
// into the result register, which drives the result channel.
// Throughput: one transaction per cycle; the result register decouples the two sides,
// and the input stalls only while a result waits and the input register is full.
// Reset (rst_ni low, asynchronous): all machines in reset phase, flags and
// actuators cleared, held status waiting, registers at defaults (hot limit 255).
`default_nettype none

module greenhouse_climate_supervisor_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gsup_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [gsup_pkg::CfgWidth-1:0] cfg_data_i,
  gsup_in_if.sink                            in_i,
  gsup_out_if.source                         out_o
);

  gsup_pkg::cfg_t      cfg;
  gsup_pkg::tick_in_t  in_item;
  gsup_pkg::tick_in_t  s1_data_q;
  gsup_pkg::tick_out_t res;
  gsup_pkg::tick_out_t out_data_q;
  logic                s1_valid_q, s1_valid_d;
  logic                out_valid_q, out_valid_d;
  logic                advance, s1_fire, in_fire;

  gsup_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign in_item.care_request   = in_i.care_request;
  assign in_item.soil_moisture  = in_i.soil_moisture;
  assign in_item.air_humidity   = in_i.air_humidity;
  assign in_item.temperature    = in_i.temperature;
  assign in_item.tank_level_low = in_i.tank_level_low;
  assign in_item.valve_time_up  = in_i.valve_time_up;
  assign in_item.settle_time_up = in_i.settle_time_up;

  assign advance    = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire)      s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (s1_fire)           out_valid_d = 1'b1;
    else if (out_o.ready)  out_valid_d = 1'b0;
  end

  gsup_tick u_tick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .cfg_i  (cfg),
    .item_i (s1_data_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_data_q  <= in_item;
    if (s1_fire) out_data_q <= res;
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.valve_open         = out_data_q.valve_open;
  assign out_o.alarm_active       = out_data_q.alarm_active;
  assign out_o.fan_running        = out_data_q.fan_running;
  assign out_o.lamp_lit           = out_data_q.lamp_lit;
  assign out_o.begin_valve_timer  = out_data_q.begin_valve_timer;
  assign out_o.begin_settle_timer = out_data_q.begin_settle_timer;
  assign out_o.cancel_timers      = out_data_q.cancel_timers;
  assign out_o.caring_active      = out_data_q.caring_active;
  assign out_o.status_code        = out_data_q.status_code;

`ifndef SYNTHESIS
  a_stall_only_on_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without result backpressure");

  a_cancel_drops_settle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.cancel_timers) |-> !out_o.begin_settle_timer)
    else $error("settle timer started in a cancel transaction");

  a_caring_not_waiting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.caring_active) |->
      (out_o.status_code != gsup_pkg::ST_WAITING))
    else $error("waiting status reported while caring");

  a_result_follows_fire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_o.valid)
    else $error("result lost after tick");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/greenhouse_climate_supervisor_unit_tb.sv
// Self-checking testbench: random and directed control ticks against a tick-level predictor.
`timescale 1ns / 100ps

module greenhouse_climate_supervisor_unit_tb;
  import gsup_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 250;
  localparam int unsigned PhaseItems = 160;
  localparam int unsigned NumPhases  = 10;

  // Tick-level model of the four chained machines plus the queue of results it predicts.
  class tick_scoreboard;
    logic [7:0] hum_low, soil_target, soil_start, cold_limit, hot_limit;
    bit         from_tank;

    sup_phase_e           sup_ph;
    irr_phase_e           irr_ph;
    hum_phase_e           hum_ph;
    thr_phase_e           thr_ph;
    bit                   caring;
    logic [NumFlags-1:0]  flags;
    logic [NumActs-1:0]   acts;
    status_e              held;

    tick_out_t            expected_q[$];
    int                   errors;

    function new();
      hum_low = 8'd0; soil_target = 8'd0; soil_start = 8'd0;
      cold_limit = 8'd0; hot_limit = 8'd255; from_tank = 1'b0;
      sup_ph = SUP_RESET; irr_ph = IRR_RESET; hum_ph = HUM_RESET; thr_ph = THR_RESET;
      caring = 1'b0; flags = '0; acts = '0; held = ST_WAITING;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [7:0] d);
      case (idx)
        CFG_HUM_LOW:     hum_low = d;
        CFG_SOIL_TARGET: soil_target = d;
        CFG_SOIL_START:  soil_start = d;
        CFG_COLD_LIMIT:  cold_limit = d;
        CFG_HOT_LIMIT:   hot_limit = d;
        CFG_SUPPLY_TANK: from_tank = d[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_tick(tick_in_t t);
      logic [7:0] hum_hi, cold_off, hot_off;
      bit         empty, st_valve, st_settle, st_cancel;
      status_e    s;
      tick_out_t  e;
      hum_hi   = hum_low + Hyst;
      cold_off = cold_limit + Hyst;
      hot_off  = hot_limit - Hyst;
      empty    = from_tank && t.tank_level_low;
      st_valve = 1'b0; st_settle = 1'b0; st_cancel = 1'b0;

      case (sup_ph)
        SUP_RESET: begin
          caring = 1'b0; sup_ph = SUP_WAIT;
        end
        SUP_WAIT: begin
          flags[FlWait] = 1'b1;
          if (t.care_request) begin
            caring = 1'b1; sup_ph = SUP_CARE;
            flags[FlCare] = 1'b1; flags[FlWait] = 1'b0;
          end
        end
        SUP_CARE: begin
          if (!t.care_request) begin
            flags[FlCare] = 1'b0; caring = 1'b0; sup_ph = SUP_WAIT;
          end
        end
        default: sup_ph = SUP_RESET;
      endcase

      case (irr_ph)
        IRR_RESET: begin
          acts[ActValve] = 1'b0; acts[ActAlarm] = 1'b0; irr_ph = IRR_IDLE;
        end
        IRR_IDLE: if (caring) irr_ph = IRR_WATERED;
        IRR_WATERED: begin
          if (t.soil_moisture < soil_start && !empty) begin
            acts[ActValve] = 1'b1; st_valve = 1'b1; flags[FlWater] = 1'b1;
            irr_ph = IRR_WATERING;
          end
          if (empty) begin
            acts[ActAlarm] = 1'b1; flags[FlAlarm] = 1'b1; irr_ph = IRR_ALARM;
          end
          if (!caring) irr_ph = IRR_IDLE;
        end
        IRR_WATERING: begin
          if (t.valve_time_up) begin
            st_settle = 1'b1; acts[ActValve] = 1'b0;
          end
          // a cancel withdraws any begin strobe raised earlier in the tick
          if (empty) begin
            acts[ActValve] = 1'b0; st_cancel = 1'b1; st_valve = 1'b0; st_settle = 1'b0;
            acts[ActAlarm] = 1'b1; flags[FlAlarm] = 1'b1; irr_ph = IRR_ALARM;
          end
          if (t.soil_moisture >= soil_target) begin
            acts[ActValve] = 1'b0; st_cancel = 1'b1; st_valve = 1'b0; st_settle = 1'b0;
            flags[FlWater] = 1'b0; irr_ph = IRR_WATERED;
          end
          if (t.settle_time_up && t.soil_moisture <= soil_target) begin
            acts[ActValve] = 1'b1; st_valve = 1'b1; irr_ph = IRR_WATERING;
          end
          if (!caring) begin
            acts[ActValve] = 1'b0; st_cancel = 1'b1; st_valve = 1'b0; st_settle = 1'b0;
            flags[FlWater] = 1'b0; irr_ph = IRR_IDLE;
          end
        end
        IRR_ALARM: begin
          if (!empty) begin
            acts[ActAlarm] = 1'b0; flags[FlAlarm] = 1'b0; irr_ph = IRR_WATERED;
          end
          if (!caring) begin
            acts[ActAlarm] = 1'b0; flags[FlAlarm] = 1'b0; irr_ph = IRR_IDLE;
          end
        end
        default: irr_ph = IRR_RESET;
      endcase

      case (hum_ph)
        HUM_RESET: begin
          acts[ActFan] = 1'b0; hum_ph = HUM_IDLE;
        end
        HUM_IDLE: if (caring) hum_ph = HUM_CALM;
        HUM_CALM: begin
          if (t.air_humidity >= hum_hi) begin
            acts[ActFan] = 1'b1; flags[FlVent] = 1'b1; hum_ph = HUM_VENT;
          end
          if (!caring) hum_ph = HUM_IDLE;
        end
        default: begin
          if (t.air_humidity <= hum_low) begin
            // cooling keeps the shared fan running
            if (!flags[FlCool]) acts[ActFan] = 1'b0;
            flags[FlVent] = 1'b0; hum_ph = HUM_CALM;
          end
          if (!caring) begin
            acts[ActFan] = 1'b0; flags[FlVent] = 1'b0; hum_ph = HUM_IDLE;
          end
        end
      endcase

      case (thr_ph)
        THR_RESET: begin
          acts[ActLamp] = 1'b0; acts[ActFan] = 1'b0; thr_ph = THR_IDLE;
        end
        THR_IDLE: if (caring) thr_ph = THR_STABLE;
        THR_STABLE: begin
          if (t.temperature <= cold_limit) begin
            acts[ActLamp] = 1'b1; flags[FlWarm] = 1'b1; thr_ph = THR_WARM;
          end
          if (t.temperature >= hot_limit) begin
            acts[ActFan] = 1'b1; flags[FlCool] = 1'b1; thr_ph = THR_COOL;
          end
          if (!caring) begin
            flags[FlWarm] = 1'b0; flags[FlCool] = 1'b0; thr_ph = THR_IDLE;
          end
        end
        THR_WARM: begin
          if (t.temperature >= cold_off) begin
            acts[ActLamp] = 1'b0; flags[FlWarm] = 1'b0; thr_ph = THR_STABLE;
          end
          if (!caring) begin
            acts[ActLamp] = 1'b0; flags[FlWarm] = 1'b0; thr_ph = THR_IDLE;
          end
        end
        THR_COOL: begin
          if (t.temperature <= hot_off) begin
            if (!flags[FlVent]) acts[ActFan] = 1'b0;
            flags[FlCool] = 1'b0; thr_ph = THR_STABLE;
          end
          if (!caring) begin
            acts[ActFan] = 1'b0; flags[FlCool] = 1'b0; thr_ph = THR_IDLE;
          end
        end
        default: thr_ph = THR_RESET;
      endcase

      s = held;
      if (flags[FlWait])       s = ST_WAITING;
      else if (flags[FlAlarm]) s = ST_ALARM;
      else if (flags[FlWater]) s = ST_WATERING;
      else if (flags[FlWarm])  s = ST_WARMING;
      else if (flags[FlCool])  s = ST_COOLING;
      else if (flags[FlVent])  s = ST_VENTILATING;
      else if (flags[FlCare])  s = ST_CARING;
      held = s;

      e.valve_open         = acts[ActValve];
      e.alarm_active       = acts[ActAlarm];
      e.fan_running        = acts[ActFan];
      e.lamp_lit           = acts[ActLamp];
      e.begin_valve_timer  = st_valve;
      e.begin_settle_timer = st_settle;
      e.cancel_timers      = st_cancel;
      e.caring_active      = caring;
      e.status_code        = s;
      expected_q.push_back(e);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tick_out_t got);
      tick_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("valve_open",   8'(want.valve_open),   8'(got.valve_open));
      cmp_field("alarm_active", 8'(want.alarm_active), 8'(got.alarm_active));
      cmp_field("fan_running",  8'(want.fan_running),  8'(got.fan_running));
      cmp_field("lamp_lit",     8'(want.lamp_lit),     8'(got.lamp_lit));
      cmp_field("begin_valve_timer",
                8'(want.begin_valve_timer), 8'(got.begin_valve_timer));
      cmp_field("begin_settle_timer",
                8'(want.begin_settle_timer), 8'(got.begin_settle_timer));
      cmp_field("cancel_timers", 8'(want.cancel_timers), 8'(got.cancel_timers));
      cmp_field("caring_active", 8'(want.caring_active), 8'(got.caring_active));
      cmp_field("status_code",   8'(want.status_code),   8'(got.status_code));
    endfunction
  endclass

  logic                clk;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgWidth-1:0] cfg_data;

  gsup_in_if  in_if ();
  gsup_out_if out_if ();

  greenhouse_climate_supervisor_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  tick_scoreboard sb;
  bit          hold_req;
  bit          calm_tail;
  int unsigned cycle_cnt;

  // care session state of the random stimulus
  bit care_now;
  int care_left;
  bit tank_dry;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // transaction monitors on both channels
  always @(posedge clk) begin
    tick_in_t  t;
    tick_out_t r;
    if (rst_ni && in_if.valid && in_if.ready) begin
      t.care_request   = in_if.care_request;
      t.soil_moisture  = in_if.soil_moisture;
      t.air_humidity   = in_if.air_humidity;
      t.temperature    = in_if.temperature;
      t.tank_level_low = in_if.tank_level_low;
      t.valve_time_up  = in_if.valve_time_up;
      t.settle_time_up = in_if.settle_time_up;
      sb.note_tick(t);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      r.valve_open         = out_if.valve_open;
      r.alarm_active       = out_if.alarm_active;
      r.fan_running        = out_if.fan_running;
      r.lamp_lit           = out_if.lamp_lit;
      r.begin_valve_timer  = out_if.begin_valve_timer;
      r.begin_settle_timer = out_if.begin_settle_timer;
      r.cancel_timers      = out_if.cancel_timers;
      r.caring_active      = out_if.caring_active;
      r.status_code        = out_if.status_code;
      sb.check_result(r);
    end
  end

  // result receiver: random stall bursts, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic tick_in_t mk(bit c, logic [7:0] s, logic [7:0] h, logic [7:0] tp,
                                  bit tk, bit v, bit st);
    tick_in_t t;
    t.care_request = c; t.soil_moisture = s; t.air_humidity = h; t.temperature = tp;
    t.tank_level_low = tk; t.valve_time_up = v; t.settle_time_up = st;
    return t;
  endfunction

  function automatic logic [7:0] pick_near(logic [7:0] base);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom);
    if (r == 1) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return base + 8'($urandom_range(0, 14)) - 8'd7;
  endfunction

  // mostly care sessions with readings around the live thresholds, some raw noise
  function automatic tick_in_t next_tick();
    tick_in_t t;
    if (care_left == 0) begin
      care_now  = !care_now;
      care_left = care_now ? $urandom_range(8, 60) : $urandom_range(1, 6);
    end
    care_left--;
    if ($urandom_range(0, 24) == 0) tank_dry = !tank_dry;
    if ($urandom_range(0, 9) == 0) begin
      t = tick_in_t'($urandom);
      return t;
    end
    t.care_request  = care_now;
    t.soil_moisture = pick_near(($urandom_range(0, 1) != 0) ? sb.soil_start : sb.soil_target);
    t.air_humidity  = pick_near(($urandom_range(0, 1) != 0) ? sb.hum_low : sb.hum_low + Hyst);
    case ($urandom_range(0, 3))
      0:       t.temperature = pick_near(sb.cold_limit);
      1:       t.temperature = pick_near(sb.cold_limit + Hyst);
      2:       t.temperature = pick_near(sb.hot_limit);
      default: t.temperature = pick_near(sb.hot_limit - Hyst);
    endcase
    t.tank_level_low = tank_dry ^ ($urandom_range(0, 19) == 0);
    t.valve_time_up  = ($urandom_range(0, 4) == 0);
    t.settle_time_up = ($urandom_range(0, 4) == 0);
    return t;
  endfunction

  task automatic send_tick(tick_in_t t);
    if (!calm_tail && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.care_request   <= t.care_request;
    in_if.soil_moisture  <= t.soil_moisture;
    in_if.air_humidity   <= t.air_humidity;
    in_if.temperature    <= t.temperature;
    in_if.tank_level_low <= t.tank_level_low;
    in_if.valve_time_up  <= t.valve_time_up;
    in_if.settle_time_up <= t.settle_time_up;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
  endtask

  // stop offering and wait until every expected result is back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    sb.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [7:0] hl, logic [7:0] tg, logic [7:0] stt,
                               logic [7:0] cl, logic [7:0] hot, bit tank);
    write_reg(CFG_HUM_LOW, hl);
    write_reg(CFG_SOIL_TARGET, tg);
    write_reg(CFG_SOIL_START, stt);
    write_reg(CFG_COLD_LIMIT, cl);
    write_reg(CFG_HOT_LIMIT, hot);
    write_reg(CFG_SUPPLY_TANK, {7'd0, tank});
    cfg_we <= 1'b0;
  endtask

  initial begin
    sb        = new();
    hold_req  = 1'b0;
    calm_tail = 1'b0;
    cycle_cnt = 0;
    care_now  = 1'b0;
    care_left = 0;
    tank_dry  = 1'b0;
    rst_ni   <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_HUM_LOW;
    cfg_data <= '0;
    in_if.valid          <= 1'b0;
    in_if.care_request   <= 1'b0;
    in_if.soil_moisture  <= '0;
    in_if.air_humidity   <= '0;
    in_if.temperature    <= '0;
    in_if.tank_level_low <= 1'b0;
    in_if.valve_time_up  <= 1'b0;
    in_if.settle_time_up <= 1'b0;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // register defaults: cold limit 0, hot limit 255, mains supply (tank sensor ignored)
    send_tick(mk(1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0));
    send_tick(mk(1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1));
    send_tick(mk(1'b1, 8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 1'b0));
    send_tick(mk(1'b1, 8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 1'b0));
    send_tick(mk(1'b1, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0));
    send_tick(mk(1'b1, 8'd128, 8'd0,   8'd255, 1'b0, 1'b0, 1'b0));
    send_tick(mk(1'b0, 8'd128, 8'd0,   8'd255, 1'b0, 1'b0, 1'b0));
    drain();

    apply_setting(8'd100, 8'd150, 8'd80, 8'd20, 8'd40, 1'b1);
    send_tick(mk(1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0));
    // timer pulses outside watering are dropped
    send_tick(mk(1'b1, 8'd200, 8'd50,  8'd30,  1'b0, 1'b1, 1'b1));
    send_tick(mk(1'b1, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 1'b0));
    send_tick(mk(1'b1, 8'd50,  8'd255, 8'd0,   1'b0, 1'b1, 1'b0));
    send_tick(mk(1'b1, 8'd60,  8'd255, 8'd0,   1'b0, 1'b0, 1'b1));
    // target reached and settle expiry together: cancel, then valve restart
    send_tick(mk(1'b1, 8'd150, 8'd255, 8'd0,   1'b0, 1'b0, 1'b1));
    send_tick(mk(1'b1, 8'd0,   8'd255, 8'd25,  1'b0, 1'b1, 1'b0));
    // tank runs dry while watering: the cancel drops the settle strobe, settle expiry restarts the valve
    send_tick(mk(1'b1, 8'd0,   8'd255, 8'd255, 1'b1, 1'b1, 1'b1));
    send_tick(mk(1'b1, 8'd0,   8'd0,   8'd255, 1'b1, 1'b0, 1'b0));
    send_tick(mk(1'b1, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0));
    send_tick(mk(1'b1, 8'd0,   8'd255, 8'd0,   1'b1, 1'b0, 1'b0));
    send_tick(mk(1'b1, 8'd0,   8'd255, 8'd0,   1'b1, 1'b0, 1'b0));
    send_tick(mk(1'b0, 8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 1'b0));
    send_tick(mk(1'b0, 8'd0,   8'd0,   8'd128, 1'b0, 1'b0, 1'b0));
    // care dropped on the same tick as valve and lamp turn-on
    send_tick(mk(1'b1, 8'd200, 8'd50,  8'd30,  1'b0, 1'b0, 1'b0));
    send_tick(mk(1'b0, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 1'b0));
    send_tick(mk(1'b0, 8'd0,   8'd0,   8'd128, 1'b0, 1'b0, 1'b0));
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: apply_setting(8'd100, 8'd150, 8'd80,  8'd20,  8'd40,  1'b1);
        1: apply_setting(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        2: apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        3: apply_setting(8'd251, 8'd200, 8'd210, 8'd253, 8'd3,   1'b1);
        default: apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 1'($urandom_range(0, 1)));
      endcase
      if (p == 3) hold_req = 1'b1;
      if (p == NumPhases - 1) calm_tail = 1'b1;
      repeat (PhaseItems) send_tick(next_tick());
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
